// ===== rtl/message_retry_and_link_timer_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the message retry and link timer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MESSAGE_RETRY_AND_LINK_TIMER_TOP_DEFINES_SVH
`define MESSAGE_RETRY_AND_LINK_TIMER_TOP_DEFINES_SVH

// same-cycle implication
`define MRLT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrlt assertion failed");

// next-cycle implication
`define MRLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrlt assertion failed");

`endif

// ===== rtl/mrlt_pkg.sv =====
// ---------------------------------------------------------------------------
// mrlt_pkg
// Types, widths, register indexes and reset values of the retry/link timer.
// ---------------------------------------------------------------------------
package mrlt_pkg;

  localparam int CountW    = 16;
  localparam int SentW     = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 8;
  localparam int InFields  = 6;
  localparam int OutFields = 5;

  typedef logic [CountW-1:0] count_t;
  typedef logic [SentW-1:0]  sent_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIRECT_PERIOD    = 3'd0,
    REG_CLEANUP_PERIOD   = 3'd1,
    REG_LINK_PERIOD      = 3'd2,
    REG_RETRY_LIMIT      = 3'd3,
    REG_TICKS_PER_SECOND = 3'd4,
    REG_LINK_TIMEOUT     = 3'd5
  } cfg_reg_t;

  localparam count_t DirectPeriodRst   = 16'd200;
  localparam count_t CleanupPeriodRst  = 16'd200;
  localparam count_t LinkPeriodRst     = 16'd500;
  localparam sent_t  RetryLimitRst     = 4'd3;
  localparam count_t TicksPerSecondRst = 16'd1000;
  localparam count_t LinkTimeoutRst    = 16'd240;

  // one millisecond tick
  typedef struct packed {
    logic direct_enable;
    logic cleanup_enable;
    logic direct_restart;
    logic cleanup_restart;
    logic link_arm;
    logic start_link;
  } tick_t;

  // per-channel status for this tick
  typedef struct packed {
    logic send;     // retransmission requested
    logic exhaust;  // period reached with retries used up
  } chan_stat_t;

endpackage

// ===== rtl/message_retry_and_link_timer_top.sv =====
// ---------------------------------------------------------------------------
// message_retry_and_link_timer_top
// Direct, cleanup and link retransmission timers with a linking timeout.
// ---------------------------------------------------------------------------
// One input transaction is one millisecond tick and yields exactly one result
// transaction. A tick goes through an input register and then a result
// register; the result register loads once the tick is in the input register
// and the output is empty or being taken. One tick is taken every cycle while
// the output is not stalled; the channel and seconds counters count, compare
// and update combinationally. While a result waits on the output, the input
// register takes one more tick and then holds off. Registers are to be written
// only while idle by the user; the block itself does not enforce this.
module message_retry_and_link_timer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] direct_enable [1] cleanup_enable [2] direct_restart
  // [3] cleanup_restart [4] link_arm [5] start_link [7:6] zero
  input  logic [mrlt_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] send_direct [1] send_cleanup [2] send_link
  // [3] link_retry_active [4] linking_active [7:5] zero
  output logic [mrlt_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [mrlt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mrlt_pkg::CfgDataW-1:0]  cfg_data
);
  import mrlt_pkg::*;

  count_t direct_period, cleanup_period, link_period;
  count_t ticks_per_second, link_timeout;
  sent_t  retry_limit;

  tick_t      item;
  logic       item_valid, step;
  chan_stat_t direct_stat, cleanup_stat, link_stat;
  logic       link_flag, link_active, link_flag_next, linking_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_period    <= DirectPeriodRst;
      cleanup_period   <= CleanupPeriodRst;
      link_period      <= LinkPeriodRst;
      retry_limit      <= RetryLimitRst;
      ticks_per_second <= TicksPerSecondRst;
      link_timeout     <= LinkTimeoutRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIRECT_PERIOD:    direct_period    <= cfg_data;
        REG_CLEANUP_PERIOD:   cleanup_period   <= cfg_data;
        REG_LINK_PERIOD:      link_period      <= cfg_data;
        REG_RETRY_LIMIT:      retry_limit      <= cfg_data[SentW-1:0];
        REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        REG_LINK_TIMEOUT:     link_timeout     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step = item_valid && (!m_axis_tvalid || m_axis_tready);

  mrlt_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take          (step),
    .valid         (item_valid),
    .item          (item)
  );

  mrlt_chan u_direct (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .active        (item.direct_enable),
    .restart       (item.direct_restart),
    .give_up_clear (1'b0),
    .period        (direct_period),
    .limit         (retry_limit),
    .stat          (direct_stat)
  );

  mrlt_chan u_cleanup (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .active        (item.cleanup_enable),
    .restart       (item.cleanup_restart),
    .give_up_clear (1'b0),
    .period        (cleanup_period),
    .limit         (retry_limit),
    .stat          (cleanup_stat)
  );

  // arm takes effect before the tick is counted
  assign link_active    = item.link_arm || link_flag;
  assign link_flag_next = link_active && !link_stat.exhaust;

  mrlt_chan u_link (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .active        (link_active),
    .restart       (item.link_arm),
    .give_up_clear (1'b1),
    .period        (link_period),
    .limit         (retry_limit),
    .stat          (link_stat)
  );

  mrlt_secs u_secs (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .start            (item.start_link),
    .ticks_per_second (ticks_per_second),
    .timeout          (link_timeout),
    .linking_next     (linking_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      link_flag <= 1'b0;
    end else if (step) begin
      link_flag <= link_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {{(OutDataW-OutFields){1'b0}}, linking_next, link_flag_next,
                       link_stat.send, cleanup_stat.send, direct_stat.send};
    end
  end

endmodule

// ===== rtl/mrlt_in_reg.sv =====
// ---------------------------------------------------------------------------
// mrlt_in_reg
// Input register: captures one tick transaction and unpacks its fields.
// ---------------------------------------------------------------------------
module mrlt_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mrlt_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          take,
  output logic                          valid,
  output mrlt_pkg::tick_t               item
);
  import mrlt_pkg::*;

  logic [InFields-1:0] data;

  assign s_axis_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data <= s_axis_tdata[InFields-1:0];
    end
  end

  always_comb begin
    item.direct_enable   = data[0];
    item.cleanup_enable  = data[1];
    item.direct_restart  = data[2];
    item.cleanup_restart = data[3];
    item.link_arm        = data[4];
    item.start_link      = data[5];
  end

endmodule

// ===== rtl/mrlt_chan.sv =====
// ---------------------------------------------------------------------------
// mrlt_chan
// One retransmission channel: period counter and sent counter.
// ---------------------------------------------------------------------------
module mrlt_chan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 active,
  input  logic                 restart,
  input  logic                 give_up_clear,
  input  mrlt_pkg::count_t     period,
  input  mrlt_pkg::sent_t      limit,
  output mrlt_pkg::chan_stat_t stat
);
  import mrlt_pkg::*;

  count_t count, count_next, count_base, count_inc;
  sent_t  sent, sent_next, sent_base;
  logic   hit, below;

  always_comb begin
    count_base = restart ? '0 : count;
    sent_base  = restart ? '0 : sent;
    count_inc  = count_base + count_t'(1);
    hit        = active && (count_inc >= period);
    below      = sent_base < limit;
    stat.send    = hit && below;
    stat.exhaust = hit && !below;
    count_next = active ? (hit ? '0 : count_inc) : count_base;
    if (hit && below) begin
      sent_next = sent_base + sent_t'(1);
    end else if (hit && give_up_clear) begin
      sent_next = '0;
    end else begin
      sent_next = sent_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sent  <= '0;
    end else if (step) begin
      count <= count_next;
      sent  <= sent_next;
    end
  end

endmodule

// ===== rtl/mrlt_secs.sv =====
// ---------------------------------------------------------------------------
// mrlt_secs
// Tick-to-second divider and linking timeout.
// ---------------------------------------------------------------------------
module mrlt_secs (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             start,
  input  mrlt_pkg::count_t ticks_per_second,
  input  mrlt_pkg::count_t timeout,
  output logic             linking_next
);
  import mrlt_pkg::*;

  count_t tick_count, tick_next, tick_inc;
  count_t secs, secs_base, secs_next;
  logic   linking, linking_base, sec_edge;

  always_comb begin
    tick_inc     = tick_count + count_t'(1);
    sec_edge     = tick_inc >= ticks_per_second;
    tick_next    = sec_edge ? '0 : tick_inc;
    linking_base = start || linking;
    secs_base    = start ? '0 : secs;
    linking_next = linking_base;
    secs_next    = secs_base;
    if (sec_edge && linking_base) begin
      // compare uses the count before this second is added
      if (secs_base >= timeout) begin
        linking_next = 1'b0;
        secs_next    = '0;
      end else begin
        secs_next = secs_base + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      secs       <= '0;
      linking    <= 1'b0;
    end else if (step) begin
      tick_count <= tick_next;
      secs       <= secs_next;
      linking    <= linking_next;
    end
  end

endmodule

// ===== rtl/mrlt_checker.sv =====
// ---------------------------------------------------------------------------
// mrlt_checker
// Port-level checks of the retry/link timer, bound to the top level.
// ---------------------------------------------------------------------------
`include "message_retry_and_link_timer_top_defines.svh"

module mrlt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mrlt_pkg::OutDataW-1:0] m_axis_tdata
);
  import mrlt_pkg::*;

  // an empty result register never blocks the input side
  `MRLT_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)

  // a link retransmission leaves the link retry flag set
  `MRLT_ASSERT_NOW(a_send_link_flag, clk, rst, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[3])

  // stalled result holds
  `MRLT_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // accepted tick with an empty result register is followed by a valid result
  `MRLT_ASSERT_NEXT(a_result_follows, clk, rst, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, ##1 m_axis_tvalid)

endmodule

bind message_retry_and_link_timer_top mrlt_checker u_mrlt_checker (.*);

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench for message_retry_and_link_timer_top
// Drives one-millisecond ticks over the input stream and writes the timer
// registers between phases while the block is idle. Each tick is run through
// a local copy of the channel and seconds counters. Every result transaction
// is checked field by field against that prediction. Random sender gaps and
// receiver stalls are mixed with stretches at full rate.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mrlt_pkg::*;

  // result fields, send_direct in bit 0 as on m_axis_tdata
  typedef struct packed {
    logic linking_active;
    logic link_retry_active;
    logic send_link;
    logic send_cleanup;
    logic send_direct;
  } timer_status_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  message_retry_and_link_timer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL message_retry_and_link_timer_top");
    $finish;
  end

  // timer registers as last written
  count_t direct_period_r, cleanup_period_r, link_period_r;
  count_t ticks_per_second_r, link_timeout_r;
  sent_t  retry_limit_r;

  // counter state
  count_t ms_count, seconds_count;
  count_t direct_count, cleanup_count, link_count;
  sent_t  direct_sent, cleanup_sent, link_sent;
  logic   link_retry_on, linking_on;

  timer_status_t expected_status_q[$];

  int unsigned ticks_sent, results_seen, settings_used, fail_count;
  int unsigned direct_sends, cleanup_sends, link_sends, link_giveups, link_timeouts;
  int unsigned burst_left;
  logic        direct_level, cleanup_level;

  function automatic void timers_reset();
    direct_period_r    = DirectPeriodRst;
    cleanup_period_r   = CleanupPeriodRst;
    link_period_r      = LinkPeriodRst;
    retry_limit_r      = RetryLimitRst;
    ticks_per_second_r = TicksPerSecondRst;
    link_timeout_r     = LinkTimeoutRst;
    ms_count       = '0;
    seconds_count  = '0;
    direct_count   = '0;
    cleanup_count  = '0;
    link_count     = '0;
    direct_sent    = '0;
    cleanup_sent   = '0;
    link_sent      = '0;
    link_retry_on  = 1'b0;
    linking_on     = 1'b0;
  endfunction

  // counts never wrap past the compare: a count above the period hits at once
  function automatic logic period_reached(inout count_t cnt, input count_t period);
    cnt = cnt + 16'd1;
    if (cnt >= period) begin
      cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic timer_status_t predict_tick(tick_t t);
    timer_status_t r;
    count_t        prior_seconds;
    r = '0;
    // pulses act before the tick is counted
    if (t.direct_restart) begin
      direct_count = '0;
      direct_sent  = '0;
    end
    if (t.cleanup_restart) begin
      cleanup_count = '0;
      cleanup_sent  = '0;
    end
    if (t.link_arm) begin
      link_retry_on = 1'b1;
      link_count    = '0;
      link_sent     = '0;
    end
    if (t.start_link) begin
      linking_on    = 1'b1;
      seconds_count = '0;
    end
    ms_count = ms_count + 16'd1;
    if (t.direct_enable) begin
      if (period_reached(direct_count, direct_period_r)) begin
        if (direct_sent < retry_limit_r) begin
          r.send_direct = 1'b1;
          direct_sent   = direct_sent + 4'd1;
          direct_sends++;
        end
      end
    end
    if (t.cleanup_enable) begin
      if (period_reached(cleanup_count, cleanup_period_r)) begin
        if (cleanup_sent < retry_limit_r) begin
          r.send_cleanup = 1'b1;
          cleanup_sent   = cleanup_sent + 4'd1;
          cleanup_sends++;
        end
      end
    end
    if (link_retry_on) begin
      if (period_reached(link_count, link_period_r)) begin
        if (link_sent < retry_limit_r) begin
          r.send_link = 1'b1;
          link_sent   = link_sent + 4'd1;
          link_sends++;
        end else begin
          link_retry_on = 1'b0;
          link_sent     = '0;
          link_giveups++;
        end
      end
    end
    if (ms_count >= ticks_per_second_r) begin
      ms_count = '0;
      if (linking_on) begin
        // compare uses the count before this second is added
        prior_seconds = seconds_count;
        seconds_count = seconds_count + 16'd1;
        if (prior_seconds >= link_timeout_r) begin
          linking_on    = 1'b0;
          seconds_count = '0;
          link_timeouts++;
        end
      end
    end
    r.link_retry_active = link_retry_on;
    r.linking_active    = linking_on;
    return r;
  endfunction

  function automatic tick_t mk_tick(logic d_en, logic c_en, logic d_rs, logic c_rs,
                                    logic arm, logic start);
    tick_t t;
    t.direct_enable   = d_en;
    t.cleanup_enable  = c_en;
    t.direct_restart  = d_rs;
    t.cleanup_restart = c_rs;
    t.link_arm        = arm;
    t.start_link      = start;
    return t;
  endfunction

  // enables held as levels for stretches, pulses sparse, some pure noise
  function automatic tick_t random_tick(logic quiet);
    tick_t t;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      t = tick_t'($urandom_range(0, 63));
      return t;
    end
    if ($urandom_range(0, 24) == 0) direct_level = ~direct_level;
    if ($urandom_range(0, 24) == 0) cleanup_level = ~cleanup_level;
    t.direct_enable   = direct_level;
    t.cleanup_enable  = cleanup_level;
    if (quiet) begin
      t.direct_restart  = ($urandom_range(0, 499) == 0);
      t.cleanup_restart = ($urandom_range(0, 499) == 0);
      t.link_arm        = ($urandom_range(0, 499) == 0);
      t.start_link      = ($urandom_range(0, 499) == 0);
    end else begin
      t.direct_restart  = ($urandom_range(0, 29) == 0);
      t.cleanup_restart = ($urandom_range(0, 29) == 0);
      t.link_arm        = ($urandom_range(0, 39) == 0);
      t.start_link      = ($urandom_range(0, 59) == 0);
    end
    return t;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  task automatic send_tick(tick_t t);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t.start_link, t.link_arm, t.cleanup_restart,
                      t.direct_restart, t.cleanup_enable, t.direct_enable};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_status_q.push_back(predict_tick(t));
    ticks_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, count_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DIRECT_PERIOD:    direct_period_r    = val;
      REG_CLEANUP_PERIOD:   cleanup_period_r   = val;
      REG_LINK_PERIOD:      link_period_r      = val;
      REG_RETRY_LIMIT:      retry_limit_r      = val[SentW-1:0];
      REG_TICKS_PER_SECOND: ticks_per_second_r = val;
      REG_LINK_TIMEOUT:     link_timeout_r     = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(count_t dp, count_t cp, count_t lp, count_t rl,
                                count_t tps, count_t tmo);
    wait_idle();
    cfg_write(REG_DIRECT_PERIOD, dp);
    cfg_write(REG_CLEANUP_PERIOD, cp);
    cfg_write(REG_LINK_PERIOD, lp);
    cfg_write(REG_RETRY_LIMIT, rl);
    cfg_write(REG_TICKS_PER_SECOND, tps);
    cfg_write(REG_LINK_TIMEOUT, tmo);
    settings_used++;
  endtask

  task automatic run_random_ticks(int unsigned n, logic quiet);
    repeat (n) send_tick(random_tick(quiet));
  endtask

  // ---- result checker ----
  timer_status_t got_status, want_status;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got_status = timer_status_t'(m_axis_tdata[OutFields-1:0]);
      if (expected_status_q.size() == 0) begin
        note_failure($sformatf("unexpected result transaction tdata=%02h", m_axis_tdata));
      end else begin
        want_status = expected_status_q.pop_front();
        if (got_status.send_direct !== want_status.send_direct ||
            got_status.send_cleanup !== want_status.send_cleanup ||
            got_status.send_link !== want_status.send_link ||
            got_status.link_retry_active !== want_status.link_retry_active ||
            got_status.linking_active !== want_status.linking_active ||
            m_axis_tdata[OutDataW-1:OutFields] !== '0) begin
          note_failure($sformatf(
            {"result %0d mismatch: exp sd=%b sc=%b sl=%b lr=%b la=%b pad=0 ",
             "got sd=%b sc=%b sl=%b lr=%b la=%b pad=%b"},
            results_seen, want_status.send_direct, want_status.send_cleanup,
            want_status.send_link, want_status.link_retry_active,
            want_status.linking_active, got_status.send_direct, got_status.send_cleanup,
            got_status.send_link, got_status.link_retry_active, got_status.linking_active,
            m_axis_tdata[OutDataW-1:OutFields]));
        end
      end
    end
  end

  // ---- receiver: mode and the length of its stretch are picked at random ----
  int unsigned rx_left;
  int unsigned rx_mode;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ((rx_left & 15) < 4);  // long stalls
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // ---- tests ----
  task automatic test_basic_ticks();
    apply_settings(16'd1, 16'd2, 16'd3, 16'd2, 16'd2, 16'd0);
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(1, 1, 1, 1, 1, 1));  // every pulse with the tick
    send_tick(mk_tick(1, 0, 0, 0, 0, 0));
    send_tick(mk_tick(1, 1, 0, 1, 0, 0));
    send_tick(mk_tick(0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(1, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, 0, 1, 1));
  endtask

  task automatic test_zero_period();
    // a zero period hits on every active tick
    apply_settings(16'd0, 16'd0, 16'd0, 16'd15, 16'd1, 16'd2);
    send_tick(mk_tick(1, 1, 1, 1, 1, 1));
    repeat (3) send_tick(mk_tick(1, 1, 0, 0, 0, 0));
  endtask

  task automatic test_retry_limit_zero();
    // nothing sent; link flag drops at its first period
    apply_settings(16'd2, 16'd2, 16'd2, 16'd0, 16'd3, 16'd1);
    send_tick(mk_tick(1, 1, 1, 1, 1, 0));
    repeat (3) send_tick(mk_tick(1, 1, 0, 0, 0, 0));
  endtask

  task automatic test_period_lowered();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15, 16'd3, 16'd2);
    send_tick(mk_tick(1, 1, 0, 0, 1, 1));
    repeat (6) send_tick(mk_tick(1, 1, 0, 0, 0, 0));
    wait_idle();
    cfg_write(REG_DIRECT_PERIOD, 16'd2);
    cfg_write(REG_CLEANUP_PERIOD, 16'd2);
    cfg_write(REG_LINK_PERIOD, 16'd2);
    send_tick(mk_tick(1, 1, 0, 0, 0, 0));
    send_tick(mk_tick(1, 1, 0, 0, 0, 0));
  endtask

  task automatic test_default_settings();
    apply_settings(DirectPeriodRst, CleanupPeriodRst, LinkPeriodRst,
                   count_t'(RetryLimitRst), TicksPerSecondRst, LinkTimeoutRst);
    direct_level  = 1'b1;
    cleanup_level = 1'b1;
    send_tick(mk_tick(1, 1, 1, 1, 1, 1));
    run_random_ticks(260, 1'b1);
  endtask

  task automatic test_max_retries();
    apply_settings(count_t'($urandom_range(1, 2)), count_t'($urandom_range(1, 2)),
                   count_t'($urandom_range(1, 2)), 16'd15, 16'd1, 16'd0);
    run_random_ticks(150, 1'b0);
  endtask

  task automatic test_extreme_settings();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15, 16'hFFFF, 16'hFFFF);
    run_random_ticks(40, 1'b0);
    apply_settings(16'd1, 16'd1, 16'd1, 16'd15, 16'd1, 16'hFFFF);
    run_random_ticks(60, 1'b0);
  endtask

  task automatic test_random_settings();
    apply_settings(count_t'($urandom_range(1, 10)), count_t'($urandom_range(1, 10)),
                   count_t'($urandom_range(1, 10)), count_t'($urandom_range(0, 15)),
                   count_t'($urandom_range(1, 6)), count_t'($urandom_range(0, 5)));
    run_random_ticks(120, 1'b0);
  endtask

  initial begin
    timers_reset();
    direct_level  = 1'b0;
    cleanup_level = 1'b0;
    burst_left    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_basic_ticks();
    test_zero_period();
    test_retry_limit_zero();
    test_period_lowered();
    test_default_settings();
    test_max_retries();
    test_extreme_settings();
    repeat (5) test_random_settings();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("ran %0d ticks (%0d results) over %0d register settings",
             ticks_sent, results_seen, settings_used);
    $display("retransmits direct/cleanup/link %0d/%0d/%0d, link give-ups %0d, timeouts %0d",
             direct_sends, cleanup_sends, link_sends, link_giveups, link_timeouts);
    if (fail_count == 0) begin
      $display("PASS message_retry_and_link_timer_top");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAIL message_retry_and_link_timer_top");
    end
    $finish;
  end

endmodule
